/* rtl/ign2d_pkg.sv */
// ----------------------------------------------------------------------------
// ign2d_pkg: shared types and constants for the gradient noise pipeline
// Permutation table, stage enable bundle and elaboration-time fade helper.
// ----------------------------------------------------------------------------
package ign2d_pkg;

	// standard improved-noise permutation
	localparam logic [7:0] PERM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
		8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
		8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
		8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
		8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
		8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
		8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
		8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
		8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
		8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
		8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
		8'd215,8'd61,8'd156,8'd180
	};

	// per-stage load enables
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
		logic s9;
	} stage_en_t;

	function automatic longint mulq_c(longint a, longint b, int f);
		return (a * b + (64'sd1 <<< (f - 1))) >>> f;
	endfunction

	// fade of the fixed depth 0.8, worked out at elaboration
	function automatic longint fade_const(int f);
		longint one;
		longint t;
		longint p;
		one = 64'sd1 <<< f;
		t = ((64'sd8 <<< f) + 64'sd5) / 64'sd10;
		p = mulq_c(t, 64'sd6 * t - 64'sd15 * one, f) + 64'sd10 * one;
		return mulq_c(t, mulq_c(t, mulq_c(t, p, f), f), f);
	endfunction

endpackage

/* rtl/ign2d_fade.sv */
// ----------------------------------------------------------------------------
// ign2d_fade: quintic fade curve
// Four multiply stages, one rounded product per stage (s2..s5).
// ----------------------------------------------------------------------------
module ign2d_fade #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  ign2d_pkg::stage_en_t             en,
	input  logic [FRAC_BITS-1:0]             t_in,
	output logic signed [FRAC_BITS+5:0]      fade_s5
);
	localparam int DW = FRAC_BITS + 6;
	localparam int PW = 2 * DW;
	localparam logic signed [DW-1:0] ONE = DW'(1) <<< FRAC_BITS;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

	function automatic logic signed [DW-1:0] mulq(logic signed [DW-1:0] a,
		logic signed [DW-1:0] b);
		logic signed [PW-1:0] p;
		p = PW'(a) * PW'(b);
		p = p + HALF;
		return DW'(p >>> FRAC_BITS);
	endfunction

	logic signed [DW-1:0] t0;
	logic signed [DW-1:0] t_s2, t_s3, t_s4;
	logic signed [DW-1:0] a_s2, a_s3, a_s4;

	assign t0 = DW'({1'b0, t_in});

	always_ff @(posedge clk) begin
		if (en.s2) begin
			t_s2 <= t0;
			a_s2 <= mulq(t0, DW'(6) * t0 - DW'(15) * ONE);
		end
		if (en.s3) begin
			t_s3 <= t_s2;
			a_s3 <= mulq(t_s2, a_s2 + DW'(10) * ONE);
		end
		if (en.s4) begin
			t_s4 <= t_s3;
			a_s4 <= mulq(t_s3, a_s3);
		end
		if (en.s5) begin
			fade_s5 <= mulq(t_s4, a_s4);
		end
	end
endmodule

/* rtl/ign2d_corner.sv */
// ----------------------------------------------------------------------------
// ign2d_corner: lattice corner hashing and gradient selection
// Three permutation lookups in s2..s4, gradient dot products into s5.
// ----------------------------------------------------------------------------
module ign2d_corner #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  ign2d_pkg::stage_en_t          en,
	input  logic [7:0]                    x_cell,
	input  logic [7:0]                    y_cell,
	input  logic [FRAC_BITS-1:0]          x_frac,
	input  logic [FRAC_BITS-1:0]          y_frac,
	output logic signed [FRAC_BITS+5:0]   grad_s5 [8]
);
	localparam int DW = FRAC_BITS + 6;
	localparam logic signed [DW-1:0] ONE = DW'(1) <<< FRAC_BITS;
	localparam logic signed [DW-1:0] FZ =
		DW'(((64'd8 << FRAC_BITS) + 64'd5) / 64'd10);

	function automatic logic signed [DW-1:0] grad(logic [3:0] h,
		logic signed [DW-1:0] x, logic signed [DW-1:0] y, logic signed [DW-1:0] z);
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		a = (h < 4'd8) ? x : y;
		b = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
		if (h[0]) a = -a;
		if (h[1]) b = -b;
		return a + b;
	endfunction

	logic [7:0] a_s2, b_s2;
	logic [7:0] aa_s3, ab_s3, ba_s3, bb_s3;
	logic [7:0] h_s4 [8];
	logic [FRAC_BITS-1:0] fx_s2, fx_s3, fx_s4, fy_s2, fy_s3, fy_s4;
	logic signed [DW-1:0] x0, x1, y0, y1;

	assign x0 = DW'({1'b0, fx_s4});
	assign y0 = DW'({1'b0, fy_s4});
	assign x1 = x0 - ONE;
	assign y1 = y0 - ONE;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			a_s2  <= ign2d_pkg::PERM[x_cell] + y_cell;
			b_s2  <= ign2d_pkg::PERM[x_cell + 8'd1] + y_cell;
			fx_s2 <= x_frac;
			fy_s2 <= y_frac;
		end
		if (en.s3) begin
			aa_s3 <= ign2d_pkg::PERM[a_s2];
			ab_s3 <= ign2d_pkg::PERM[a_s2 + 8'd1];
			ba_s3 <= ign2d_pkg::PERM[b_s2];
			bb_s3 <= ign2d_pkg::PERM[b_s2 + 8'd1];
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
		end
		if (en.s4) begin
			h_s4[0] <= ign2d_pkg::PERM[aa_s3];
			h_s4[1] <= ign2d_pkg::PERM[ba_s3];
			h_s4[2] <= ign2d_pkg::PERM[ab_s3];
			h_s4[3] <= ign2d_pkg::PERM[bb_s3];
			h_s4[4] <= ign2d_pkg::PERM[aa_s3 + 8'd1];
			h_s4[5] <= ign2d_pkg::PERM[ba_s3 + 8'd1];
			h_s4[6] <= ign2d_pkg::PERM[ab_s3 + 8'd1];
			h_s4[7] <= ign2d_pkg::PERM[bb_s3 + 8'd1];
			fx_s4   <= fx_s3;
			fy_s4   <= fy_s3;
		end
		if (en.s5) begin
			grad_s5[0] <= grad(h_s4[0][3:0], x0, y0, FZ);
			grad_s5[1] <= grad(h_s4[1][3:0], x1, y0, FZ);
			grad_s5[2] <= grad(h_s4[2][3:0], x0, y1, FZ);
			grad_s5[3] <= grad(h_s4[3][3:0], x1, y1, FZ);
			grad_s5[4] <= grad(h_s4[4][3:0], x0, y0, FZ - ONE);
			grad_s5[5] <= grad(h_s4[5][3:0], x1, y0, FZ - ONE);
			grad_s5[6] <= grad(h_s4[6][3:0], x0, y1, FZ - ONE);
			grad_s5[7] <= grad(h_s4[7][3:0], x1, y1, FZ - ONE);
		end
	end
endmodule

/* rtl/ign2d_blend.sv */
// ----------------------------------------------------------------------------
// ign2d_blend: interpolation and output scaling
// x, y and z blends in s6..s8, offset, rounding and clamp into s9.
// ----------------------------------------------------------------------------
module ign2d_blend #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  ign2d_pkg::stage_en_t          en,
	input  logic signed [FRAC_BITS+5:0]   grad_s5 [8],
	input  logic signed [FRAC_BITS+5:0]   u_s5,
	input  logic signed [FRAC_BITS+5:0]   v_s5,
	output logic [16:0]                   noise_s9
);
	localparam int DW = FRAC_BITS + 6;
	localparam int PW = 2 * DW + 2;
	localparam int QW = DW + 9;
	localparam int SH = FRAC_BITS - 15;
	localparam logic signed [DW-1:0] ONE = DW'(1) <<< FRAC_BITS;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [DW-1:0] W_FADE = DW'(ign2d_pkg::fade_const(FRAC_BITS));
	localparam logic [QW-1:0] QMAX = QW'(65536);

	function automatic logic signed [DW-1:0] lerp(logic signed [DW-1:0] t,
		logic signed [DW-1:0] a, logic signed [DW-1:0] b);
		logic signed [PW-1:0] d;
		logic signed [PW-1:0] p;
		d = PW'(b) - PW'(a);
		p = PW'(t) * d;
		p = p + HALF;
		return a + DW'(p >>> FRAC_BITS);
	endfunction

	logic signed [DW-1:0] lx_s6 [4];
	logic signed [DW-1:0] v_s6;
	logic signed [DW-1:0] n0_s7, n1_s7;
	logic signed [DW-1:0] r_s8;
	logic signed [QW-1:0] s_sum;
	logic [QW-1:0] q_scaled;

	assign s_sum = QW'(r_s8) + QW'(ONE);

	generate
		if (SH > 0) begin : g_rshift
			assign q_scaled = (QW'(s_sum) + (QW'(1) << (SH - 1))) >> SH;
		end else begin : g_lshift
			assign q_scaled = QW'(s_sum) << (-SH);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en.s6) begin
			lx_s6[0] <= lerp(u_s5, grad_s5[0], grad_s5[1]);
			lx_s6[1] <= lerp(u_s5, grad_s5[2], grad_s5[3]);
			lx_s6[2] <= lerp(u_s5, grad_s5[4], grad_s5[5]);
			lx_s6[3] <= lerp(u_s5, grad_s5[6], grad_s5[7]);
			v_s6     <= v_s5;
		end
		if (en.s7) begin
			n0_s7 <= lerp(v_s6, lx_s6[0], lx_s6[1]);
			n1_s7 <= lerp(v_s6, lx_s6[2], lx_s6[3]);
		end
		if (en.s8) begin
			r_s8 <= lerp(W_FADE, n0_s7, n1_s7);
		end
		if (en.s9) begin
			// drop negative sums, clamp the top
			if (s_sum <= 0) begin
				noise_s9 <= 17'd0;
			end else if (q_scaled > QMAX) begin
				noise_s9 <= 17'd65536;
			end else begin
				noise_s9 <= q_scaled[16:0];
			end
		end
	end
endmodule

/* rtl/improved_gradient_noise_2d.sv */
// ----------------------------------------------------------------------------
// improved_gradient_noise_2d: streaming 2D slice of improved gradient noise
// Nine-stage pipeline, one sample per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Each accepted word carries an (x, y) position in unsigned fixed point with
// FRAC_BITS fraction bits; the integer part modulo 256 picks the lattice
// cell. One result word follows per input word, in order: (noise+1)/2 as
// unsigned Q1.16, clamped to 0..65536, sampled at depth z = 0.8. An accepted
// word passes through every stage, input register to output stage, before
// out_valid rises, and the sustained rate is one word per cycle while
// out_stall is low: every stage holds one word, and the depth is set by the
// three chained permutation lookups and the four-multiply fade chain that
// run side by side, followed by three blend stages and the output stage.
// Each stage advances whenever it is empty or its successor advances, so a
// stall at the output only backs up as far as the first empty stage, and
// in_stall rises only once all nine stages are full.
// ----------------------------------------------------------------------------
module improved_gradient_noise_2d #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [23:0]   x_pos,
	input  logic [23:0]   y_pos,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [16:0]   noise_value
);
	localparam int NS = 9;
	localparam int DW = FRAC_BITS + 6;

	logic [NS:1] vld_q;
	logic [NS:1] adv;
	ign2d_pkg::stage_en_t en;

	logic [31:0] x_wide, y_wide;
	logic [7:0] x_cell_s1, y_cell_s1;
	logic [FRAC_BITS-1:0] x_frac_s1, y_frac_s1;
	logic signed [DW-1:0] grad_s5 [8];
	logic signed [DW-1:0] u_s5, v_s5;

	// advance when empty or when the next stage advances
	always_comb begin
		adv[NS] = !vld_q[NS] || !out_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign en = '{s2: adv[2], s3: adv[3], s4: adv[4], s5: adv[5],
		s6: adv[6], s7: adv[7], s8: adv[8], s9: adv[9]};

	assign in_stall  = !adv[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= in_valid;
			for (int k = 2; k <= NS; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// split position into cell and fraction; cell is always zero when FRAC_BITS is 24
	assign x_wide = {8'd0, x_pos};
	assign y_wide = {8'd0, y_pos};

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			x_cell_s1 <= x_wide[FRAC_BITS +: 8];
			y_cell_s1 <= y_wide[FRAC_BITS +: 8];
			x_frac_s1 <= x_pos[FRAC_BITS-1:0];
			y_frac_s1 <= y_pos[FRAC_BITS-1:0];
		end
	end

	ign2d_corner #(.FRAC_BITS(FRAC_BITS)) u_corner (
		.clk     (clk),
		.en      (en),
		.x_cell  (x_cell_s1),
		.y_cell  (y_cell_s1),
		.x_frac  (x_frac_s1),
		.y_frac  (y_frac_s1),
		.grad_s5 (grad_s5)
	);

	ign2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
		.clk     (clk),
		.en      (en),
		.t_in    (x_frac_s1),
		.fade_s5 (u_s5)
	);

	ign2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
		.clk     (clk),
		.en      (en),
		.t_in    (y_frac_s1),
		.fade_s5 (v_s5)
	);

	ign2d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk      (clk),
		.en       (en),
		.grad_s5  (grad_s5),
		.u_s5     (u_s5),
		.v_s5     (v_s5),
		.noise_s9 (noise_value)
	);

	// input backs up only with every stage occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q))
		else $error("input stalled with a free stage");

	// a draining output never blocks the input
	a_drain_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	// an advancing stage takes its predecessor's word
	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		(adv[5] && vld_q[4]) |=> vld_q[5])
		else $error("word lost between stages");

	// result stays within the clamp range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (noise_value <= 17'd65536))
		else $error("result beyond clamp");
endmodule
